>>> src/id3fh_pkg.sv
`default_nettype none

package id3fh_pkg;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       frame_begin;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] hdr_id;
		logic [31:0] frame_size;
		logic [15:0] frame_flags;
		logic [7:0]  payload_byte;
		logic        last;
	} out_word_t;

	localparam logic [2:0] ST_HDR  = 3'd0;
	localparam logic [2:0] ST_DONE = 3'd1;
	localparam logic [2:0] ST_DATA = 3'd2;
	localparam logic [2:0] ST_REJ  = 3'd3;
	localparam logic [2:0] ST_IGN  = 3'd4;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_ID    = 3'd1;
	localparam logic [2:0] PH_SIZE  = 3'd2;
	localparam logic [2:0] PH_FLAGS = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;

	localparam logic [2:0] VER_22    = 3'd2;
	localparam logic [2:0] VER_23    = 3'd3;
	localparam logic [2:0] VER_24    = 3'd4;
	localparam logic [2:0] LEN_SHORT = 3'd3;
	localparam logic [2:0] LEN_LONG  = 3'd4;
	localparam logic [2:0] LEN_FLAGS = 3'd2;

	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_Z = "Z";
	localparam logic [7:0] CH_DIGIT_0 = "0";
	localparam logic [7:0] CH_DIGIT_9 = "9";

	function automatic logic id_char_ok(input logic [7:0] c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
			((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
	endfunction

	// hit flag on top, then the four-character id
	function automatic logic [32:0] map_short_id(input logic [23:0] key);
		logic [32:0] r;
		case (key)
			"BUF": r = {1'b1, 32'("RBUF")};
			"COM": r = {1'b1, 32'("COMM")};
			"PIC": r = {1'b1, 32'("APIC")};
			"TAL": r = {1'b1, 32'("TALB")};
			"TBP": r = {1'b1, 32'("TBPM")};
			"TCM": r = {1'b1, 32'("TCOM")};
			"TCO": r = {1'b1, 32'("TCON")};
			"TCR": r = {1'b1, 32'("TCOP")};
			"TDA": r = {1'b1, 32'("TDAT")};
			"TDY": r = {1'b1, 32'("TDLY")};
			"TEN": r = {1'b1, 32'("TENC")};
			"TFT": r = {1'b1, 32'("TFLT")};
			"TIM": r = {1'b1, 32'("TIME")};
			"TKE": r = {1'b1, 32'("TKEY")};
			"TLA": r = {1'b1, 32'("TLAN")};
			"TLE": r = {1'b1, 32'("TLEN")};
			"TMT": r = {1'b1, 32'("TMED")};
			"TOA": r = {1'b1, 32'("TOPE")};
			"TOF": r = {1'b1, 32'("TOFN")};
			"TOL": r = {1'b1, 32'("TOLY")};
			"TOR": r = {1'b1, 32'("TORY")};
			"TOT": r = {1'b1, 32'("TOAL")};
			"TP1": r = {1'b1, 32'("TPE1")};
			"TP2": r = {1'b1, 32'("TPE2")};
			"TP3": r = {1'b1, 32'("TPE3")};
			"TP4": r = {1'b1, 32'("TPE4")};
			"TPA": r = {1'b1, 32'("TPOS")};
			"TPB": r = {1'b1, 32'("TPUB")};
			"TRC": r = {1'b1, 32'("TSRC")};
			"TRD": r = {1'b1, 32'("TRDA")};
			"TRK": r = {1'b1, 32'("TRCK")};
			"TSI": r = {1'b1, 32'("TSIZ")};
			"TSS": r = {1'b1, 32'("TSSE")};
			"TT1": r = {1'b1, 32'("TIT1")};
			"TT2": r = {1'b1, 32'("TIT2")};
			"TT3": r = {1'b1, 32'("TIT3")};
			"TXT": r = {1'b1, 32'("TEXT")};
			"TXX": r = {1'b1, 32'("TXXX")};
			"TYE": r = {1'b1, 32'("TYER")};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/id3fh_core.sv
`default_nettype none

module id3fh_core
	import id3fh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_wr_en,
	input  wire logic [2:0] cfg_wr_data,
	input  wire logic      step_en,
	input  wire in_word_t  in_word,
	output out_word_t      result
);

	logic [2:0]  tag_version_q;
	logic [2:0]  frame_version_q;
	logic [2:0]  phase_q;
	logic [2:0]  count_q;
	logic [31:0] id_q;
	logic [31:0] acc_q;
	logic [15:0] flags_q;
	logic [31:0] remain_q;

	logic [2:0]  ver, phase, count;
	logic [31:0] id, acc, remain;
	logic [15:0] flags;
	logic [2:0]  ver_d, phase_d, count_d;
	logic [31:0] id_d, acc_d, remain_d;
	logic [15:0] flags_d;
	logic        v22, v24;
	logic [2:0]  hdr_len, count_inc;
	logic [31:0] id_sh, acc_sh, remain_dec;
	logic [15:0] flags_sh;
	logic [32:0] map_res;
	logic [7:0]  b;
	logic        done;
	logic [31:0] done_size;
	logic [15:0] done_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_version_q <= VER_23;
		end else if (cfg_wr_en) begin
			tag_version_q <= cfg_wr_data;
		end
	end

	always_comb begin
		b         = in_word.stream_byte;
		ver       = in_word.frame_begin ? tag_version_q : frame_version_q;
		phase     = in_word.frame_begin ? PH_ID : phase_q;
		count     = in_word.frame_begin ? 3'd0 : count_q;
		id        = in_word.frame_begin ? 32'd0 : id_q;
		acc       = in_word.frame_begin ? 32'd0 : acc_q;
		flags     = in_word.frame_begin ? 16'd0 : flags_q;
		remain    = in_word.frame_begin ? 32'd0 : remain_q;
		v22       = (ver == VER_22);
		v24       = (ver == VER_24);
		hdr_len   = v22 ? LEN_SHORT : LEN_LONG;
		count_inc = count + 3'd1;
		id_sh     = {id[23:0], b};
		acc_sh    = v24 ? {acc[24:0], b[6:0]} : {acc[23:0], b};
		flags_sh  = {flags[7:0], b};
		remain_dec = remain - 32'd1;
		map_res   = map_short_id(id_sh[23:0]);

		ver_d      = ver;
		phase_d    = phase;
		count_d    = count;
		id_d       = id;
		acc_d      = acc;
		flags_d    = flags;
		remain_d   = remain;
		result     = '0;
		done       = 1'b0;
		done_size  = acc;
		done_flags = flags;

		case (phase)
			PH_ID: begin
				if (!id_char_ok(b)) begin
					phase_d       = PH_IDLE;
					result.status = ST_REJ;
				end else begin
					id_d          = id_sh;
					count_d       = count_inc;
					result.status = ST_HDR;
					if (count_inc == hdr_len) begin
						phase_d = PH_SIZE;
						count_d = 3'd0;
						if (v22) begin
							id_d = map_res[31:0];
							if (!map_res[32]) begin
								phase_d       = PH_IDLE;
								result.status = ST_REJ;
							end
						end
					end
				end
			end
			PH_SIZE: begin
				acc_d         = acc_sh;
				count_d       = count_inc;
				result.status = ST_HDR;
				if (count_inc == hdr_len) begin
					count_d = 3'd0;
					if (v22) begin
						flags_d    = 16'd0;
						done       = 1'b1;
						done_size  = acc_sh;
						done_flags = 16'd0;
					end else begin
						phase_d = PH_FLAGS;
					end
				end
			end
			PH_FLAGS: begin
				flags_d       = flags_sh;
				count_d       = count_inc;
				result.status = ST_HDR;
				if (count_inc == LEN_FLAGS) begin
					count_d    = 3'd0;
					done       = 1'b1;
					done_flags = flags_sh;
				end
			end
			PH_DATA: begin
				remain_d            = remain_dec;
				result.status       = ST_DATA;
				result.payload_byte = b;
				if (remain_dec == 32'd0) begin
					phase_d     = PH_IDLE;
					result.last = 1'b1;
				end
			end
			default: begin
				phase_d       = PH_IDLE;
				result.status = ST_IGN;
			end
		endcase

		if (done) begin
			result.status      = ST_DONE;
			result.hdr_id      = id;
			result.frame_size  = done_size;
			result.frame_flags = done_flags;
			result.last        = (done_size == 32'd0);
			remain_d           = done_size;
			phase_d            = (done_size == 32'd0) ? PH_IDLE : PH_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_version_q <= VER_23;
			phase_q         <= PH_IDLE;
			count_q         <= 3'd0;
			id_q            <= 32'd0;
			acc_q           <= 32'd0;
			flags_q         <= 16'd0;
			remain_q        <= 32'd0;
		end else if (step_en) begin
			frame_version_q <= ver_d;
			phase_q         <= phase_d;
			count_q         <= count_d;
			id_q            <= id_d;
			acc_q           <= acc_d;
			flags_q         <= flags_d;
			remain_q        <= remain_d;
		end
	end

endmodule

`default_nettype wire

>>> src/id3fh_out_reg.sv
`default_nettype none

module id3fh_out_reg
	import id3fh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           step_en,
	input  wire out_word_t result,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	logic      out_valid_q;
	out_word_t out_data_q;

	// slot frees when empty or being drained this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign step_en   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_data_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> src/id3v2_frame_header_parser.sv
// ID3v2 frame header parser. Takes one tag byte per word and returns one result word per
// byte, in the cycle after acceptance, at a sustained rate of one byte per clock: the whole
// parse step (id check, 2.2 id translation, size and flag shifts, payload countdown) sits
// between the parse state registers and a single output register, and input is taken
// whenever that register is empty or being read out. tag_version is sampled on the word
// with frame_begin set, so it may be rewritten between frames without disturbing the
// frame in flight.
`default_nettype none

module id3v2_frame_header_parser
	import id3fh_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_word_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_word_t       out_data
);

	logic      step_en;
	out_word_t result;

	id3fh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (step_en),
		.in_word     (in_data),
		.result      (result)
	);

	id3fh_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.step_en   (step_en),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> src/id3fh_checker.sv
`default_nettype none

module id3fh_checker
	import id3fh_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire in_word_t   in_data,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire out_word_t  out_data
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// zero-length frame ends on its header
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_DONE && out_data.frame_size == 32'd0
		|-> out_data.last)
		else $error("empty frame header without last");

	// header fields only on header complete
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_DONE
		|-> out_data.hdr_id == 32'd0 && out_data.frame_size == 32'd0 &&
			out_data.frame_flags == 16'd0)
		else $error("header fields outside header complete");

	// last only on data or header complete
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last
		|-> out_data.status == ST_DATA || out_data.status == ST_DONE)
		else $error("last on wrong status");

	// bad first id character rejects at once
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.frame_begin && !id_char_ok(in_data.stream_byte)
		|=> out_valid && out_data.status == ST_REJ)
		else $error("bad id character not rejected");

endmodule

bind id3v2_frame_header_parser id3fh_checker u_chk (.*);

`default_nettype wire
